// ===== rtl/htfd_pkg.sv =====
// Shared constants and types for the humidity/temperature frame decoder.
// No dependencies; used by the channel interfaces and all rtl modules.
package htfd_pkg;

    localparam int DATA_W  = 8;
    localparam int CAL_W   = 6;
    localparam int TEMP_W  = 11;
    localparam int HUM_W   = 7;
    localparam int RAW_W   = 16;
    localparam int CAL_C_W = 10;   // 450 + 10*cal, range 130..760

    localparam logic [DATA_W-1:0] CRC_POLY = 8'h31;
    localparam logic [DATA_W-1:0] CRC_INIT = 8'hFF;

    localparam logic [16:0]  FULL_SCALE = 17'd65535;
    localparam logic [10:0]  TEMP_SCALE = 11'd1750;
    localparam logic [10:0]  TEMP_BASE  = 11'd450;
    localparam logic [6:0]   HUM_SCALE  = 7'd100;

    // Frame byte sequencer, one-hot
    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_T_LSB = 6'b000010,
        ST_T_CRC = 6'b000100,
        ST_H_MSB = 6'b001000,
        ST_H_LSB = 6'b010000,
        ST_H_CRC = 6'b100000
    } t_state;

    // floor(1750*raw / 65535) and a flag for a nonzero remainder
    typedef struct packed {
        logic [TEMP_W-1:0] quot;
        logic              rem_nz;
    } t_tquot;

endpackage

// ===== rtl/htfd_in_if.sv =====
// Input channel: one readout byte per item with its start-of-frame flag.
// Depends on htfd_pkg for field widths.
interface htfd_in_if;
    logic                         valid;
    logic                         ready;
    logic [htfd_pkg::DATA_W-1:0]  data_byte;
    logic                         frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

// ===== rtl/htfd_out_if.sv =====
// Result channel: one decoded temperature/humidity item per frame.
// Depends on htfd_pkg for field widths.
interface htfd_out_if;
    logic                         valid;
    logic                         ready;
    logic                         temp_valid;
    logic                         temp_negative;
    logic [htfd_pkg::TEMP_W-1:0]  temp_tenths;
    logic [htfd_pkg::TEMP_W-1:0]  temp_half_steps;
    logic                         hum_valid;
    logic [htfd_pkg::HUM_W-1:0]   humidity_pct;

    modport source (output valid, output temp_valid, output temp_negative,
                    output temp_tenths, output temp_half_steps, output hum_valid,
                    output humidity_pct, input ready);
    modport sink   (input valid, input temp_valid, input temp_negative,
                    input temp_tenths, input temp_half_steps, input hum_valid,
                    input humidity_pct, output ready);
endinterface

// ===== rtl/htfd_temp_div.sv =====
// Free-running two-stage scaler: floor(1750*raw / 65535) plus remainder flag.
// Depends on htfd_pkg.
module htfd_temp_div
    import htfd_pkg::*;
(
    input  logic             i_clk,
    input  logic [RAW_W-1:0] i_raw,
    output t_tquot           o_quot
);

    localparam int PROD_W = RAW_W + TEMP_W;   // 1750*65535 < 2^27

    logic [PROD_W-1:0] r_prod;
    t_tquot            r_quot;

    logic [TEMP_W-1:0] hi;
    logic [16:0]       t;
    logic              wrap;
    logic [16:0]       rem;

    // x = hi*65536 + lo = hi*65535 + (hi + lo); hi + lo < 2*65535
    always_comb begin
        hi   = r_prod[PROD_W-1:RAW_W];
        t    = {1'b0, r_prod[RAW_W-1:0]} + {6'd0, hi};
        wrap = (t >= FULL_SCALE);
        rem  = wrap ? (t - FULL_SCALE) : t;
    end

    always_ff @(posedge i_clk) begin
        r_prod        <= PROD_W'(i_raw) * PROD_W'(TEMP_SCALE);
        r_quot.quot   <= hi + TEMP_W'(wrap);
        r_quot.rem_nz <= (rem != 17'd0);
    end

    assign o_quot = r_quot;

endmodule

// ===== rtl/humidity_temp_frame_decoder.sv =====
// Humidity/temperature readout frame decoder: top level.
// Depends on htfd_pkg, htfd_in_if, htfd_out_if and htfd_temp_div.
//
// Usage:
//   i_in carries the six readout bytes (temperature MSB, LSB, CRC, humidity
//   MSB, LSB, CRC), one per item; frame_start marks the temperature MSB and
//   restarts a frame at any point. Bytes without frame_start outside a frame
//   are dropped. Each word is checked with CRC-8, polynomial 0x31, init 0xFF.
//   After the humidity CRC byte one result item appears on o_out.
//   i_cfg_we/i_cfg_wdata write the signed calibration offset in degrees;
//   write it only while no frame result is pending.
// Timing:
//   One input item per cycle while no result is stalled on o_out. The result
//   is registered and shows up on o_out in the cycle after the last byte is
//   accepted. The temperature scaling runs in a two-stage pipeline behind the
//   raw word register; the humidity CRC byte must come after the temperature
//   LSB has passed that register and both stages, which the layout always gives.
// Reset and stall:
//   Reset (synchronous, active low) empties the result register, returns to
//   waiting for a start byte and sets the offset to zero. While a result waits
//   and o_out.ready is low, i_in.ready is low; with the result taken in the
//   same cycle a new byte is accepted, so no cycle is lost.
module humidity_temp_frame_decoder
    import htfd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAL_W-1:0] i_cfg_wdata,
    htfd_in_if.sink          i_in,
    htfd_out_if.source       o_out
);

    function automatic logic [DATA_W-1:0] crc_update(
        input logic [DATA_W-1:0] crc,
        input logic [DATA_W-1:0] b
    );
        logic [DATA_W-1:0] c;
        c = crc ^ b;
        for (int k = 0; k < DATA_W; k++) begin
            c = c[DATA_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

    // Last digit to 0 (0..4) or 5 (5..9); x/10 via *3277 >> 15, exact below 2048
    function automatic logic [TEMP_W-1:0] half_step(input logic [TEMP_W-1:0] mag);
        logic [22:0]       p;
        logic [7:0]        d;
        logic [TEMP_W-1:0] d10;
        logic [TEMP_W-1:0] rem;
        p   = 23'(mag) * 23'd3277;
        d   = p[22:15];
        d10 = (TEMP_W'(d) << 3) + (TEMP_W'(d) << 1);
        rem = mag - d10;
        return (rem > TEMP_W'(4)) ? (d10 + TEMP_W'(5)) : d10;
    endfunction

    t_state              r_state, n_state;
    logic [DATA_W-1:0]   r_crc, n_crc;
    logic                r_temp_ok, n_temp_ok;
    logic [RAW_W-1:0]    r_temp_raw, n_temp_raw;
    logic [RAW_W-1:0]    r_hum_raw, n_hum_raw;
    logic [CAL_C_W-1:0]  r_cal_c;

    logic                r_out_valid;
    logic                r_o_temp_valid, r_o_temp_neg, r_o_hum_valid;
    logic [TEMP_W-1:0]   r_o_tenths, r_o_half;
    logic [HUM_W-1:0]    r_o_hum;

    t_tquot              tq;
    logic                in_acc;
    logic                emit;
    logic [DATA_W-1:0]   crc_next;

    logic [TEMP_W-1:0]   c_ext;
    logic                t_neg;
    logic [TEMP_W-1:0]   t_mag;
    logic [22:0]         hum_prod;
    logic [HUM_W-1:0]    hum_hi;
    logic [16:0]         hum_t;
    logic [HUM_W-1:0]    hum_pct;
    logic                hum_ok;

    logic [TEMP_W-1:0]   cal_ext;

    htfd_temp_div u_temp_div (
        .i_clk  (i_clk),
        .i_raw  (r_temp_raw),
        .o_quot (tq)
    );

    assign i_in.ready = !r_out_valid || o_out.ready;
    assign in_acc     = i_in.valid && i_in.ready;

    // Frame sequencer
    always_comb begin
        n_state    = r_state;
        n_crc      = r_crc;
        n_temp_ok  = r_temp_ok;
        n_temp_raw = r_temp_raw;
        n_hum_raw  = r_hum_raw;
        emit       = 1'b0;
        crc_next   = crc_update(i_in.frame_start ? CRC_INIT : r_crc, i_in.data_byte);
        if (in_acc) begin
            if (i_in.frame_start) begin
                n_temp_raw = {i_in.data_byte, 8'd0};
                n_crc      = crc_next;
                n_state    = ST_T_LSB;
            end else begin
                unique case (r_state)
                    ST_T_LSB: begin
                        n_temp_raw = {r_temp_raw[RAW_W-1:DATA_W], i_in.data_byte};
                        n_crc      = crc_next;
                        n_state    = ST_T_CRC;
                    end
                    ST_T_CRC: begin
                        n_temp_ok = (r_crc == i_in.data_byte);
                        n_crc     = CRC_INIT;
                        n_state   = ST_H_MSB;
                    end
                    ST_H_MSB: begin
                        n_hum_raw = {i_in.data_byte, 8'd0};
                        n_crc     = crc_next;
                        n_state   = ST_H_LSB;
                    end
                    ST_H_LSB: begin
                        n_hum_raw = {r_hum_raw[RAW_W-1:DATA_W], i_in.data_byte};
                        n_crc     = crc_next;
                        n_state   = ST_H_CRC;
                    end
                    ST_H_CRC: begin
                        emit    = 1'b1;
                        n_crc   = CRC_INIT;
                        n_state = ST_IDLE;
                    end
                    default: begin
                        n_state = ST_IDLE;   // stray byte outside a frame
                    end
                endcase
            end
        end
    end

    // Result arithmetic for the humidity CRC byte
    always_comb begin
        c_ext = TEMP_W'(r_cal_c);
        t_neg = (tq.quot < c_ext);
        // below zero: ceil of the scaled value is subtracted
        t_mag = t_neg ? (c_ext - tq.quot - TEMP_W'(tq.rem_nz)) : (tq.quot - c_ext);

        hum_ok   = (r_crc == i_in.data_byte);
        hum_prod = 23'(r_hum_raw) * 23'(HUM_SCALE);
        hum_hi   = hum_prod[22:16];
        hum_t    = {1'b0, hum_prod[15:0]} + 17'(hum_hi);
        hum_pct  = hum_hi + HUM_W'(hum_t >= FULL_SCALE);
    end

    // cal offset is stored as 450 + 10*cal
    assign cal_ext = {{(TEMP_W-CAL_W){i_cfg_wdata[CAL_W-1]}}, i_cfg_wdata};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_crc       <= CRC_INIT;
            r_temp_ok   <= 1'b0;
            r_out_valid <= 1'b0;
            r_cal_c     <= CAL_C_W'(TEMP_BASE);
        end else begin
            r_state   <= n_state;
            r_crc     <= n_crc;
            r_temp_ok <= n_temp_ok;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_cal_c <= CAL_C_W'(TEMP_BASE + (cal_ext << 3) + (cal_ext << 1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_temp_raw <= n_temp_raw;
        r_hum_raw  <= n_hum_raw;
        if (emit) begin
            r_o_temp_valid <= r_temp_ok;
            r_o_temp_neg   <= r_temp_ok && t_neg;
            r_o_tenths     <= r_temp_ok ? t_mag : '0;
            r_o_half       <= r_temp_ok ? half_step(t_mag) : '0;
            r_o_hum_valid  <= hum_ok;
            r_o_hum        <= hum_ok ? hum_pct : '0;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.temp_valid      = r_o_temp_valid;
    assign o_out.temp_negative   = r_o_temp_neg;
    assign o_out.temp_tenths     = r_o_tenths;
    assign o_out.temp_half_steps = r_o_half;
    assign o_out.hum_valid       = r_o_hum_valid;
    assign o_out.humidity_pct    = r_o_hum;

`ifndef SYNTHESIS
    a_emit_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(in_acc && !i_in.frame_start && r_state == ST_H_CRC))
        else $error("result appeared without a humidity CRC byte");

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r_out_valid && !o_out.ready))
        else $error("input stalled without a pending result");

    a_temp_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_temp_valid) |->
            (!r_o_temp_neg && r_o_tenths == '0 && r_o_half == '0))
        else $error("temperature fields nonzero on bad CRC");

    a_half_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_o_half <= r_o_tenths && (r_o_tenths - r_o_half) < TEMP_W'(5)))
        else $error("half step value out of line with tenths");

    a_hum_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_hum_valid) |-> (r_o_hum == '0))
        else $error("humidity nonzero on bad CRC");
`endif

endmodule
